/* rtl/fps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fps_pkg
// shared types, Q16.16 constants and the fixed-point multiply
// ----------------------------------------------------------------------------
package fps_pkg;

  typedef logic signed [31:0] q16_t;

  localparam q16_t Q_PI     = 32'sh0003243F;
  localparam q16_t Q_TWO_PI = 32'sh0006487F;
  localparam q16_t K_LIN    = 32'sh000145F3;
  localparam q16_t K_QUAD   = 32'sh000067C1;
  localparam q16_t K_REFINE = 32'sh0000399A;

  // exact product, floor shift by 16, keep 32 bits
  function automatic q16_t qmul(input q16_t a, input q16_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[47:16];
  endfunction

endpackage : fps_pkg
`default_nettype wire

/* rtl/fixed_point_sine_q16.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_sine_q16
// Q16.16 sine by parabola and one refinement step, five-stage pipeline
// throughput: one beat per cycle while the output is not stalled, at most one multiply deep per register
// the whole pipeline holds while the output beat waits for m_tready
// reset: synchronous, clears the valid bits only
// ----------------------------------------------------------------------------
module fixed_point_sine_q16 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [31:0] angle
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // [31:0] sine
);
  import fps_pkg::*;

  logic en;
  logic vld_w;
  logic vld_p;
  q16_t x;
  q16_t y;
  q16_t sine;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tdata  = sine;

  fps_wrap u_wrap (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s_tvalid),
    .angle  (q16_t'(s_tdata)),
    .vld    (vld_w),
    .x      (x)
  );

  fps_parab u_parab (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (vld_w),
    .x      (x),
    .vld    (vld_p),
    .y      (y)
  );

  fps_refine u_refine (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (vld_p),
    .y      (y),
    .vld    (m_tvalid),
    .sine   (sine)
  );

endmodule : fixed_point_sine_q16
`default_nettype wire

/* rtl/fps_wrap.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fps_wrap
// one conditional 2*pi correction toward the range -pi..pi, one register stage
// ----------------------------------------------------------------------------
module fps_wrap (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_vld,
  input  wire fps_pkg::q16_t angle,
  output logic              vld,
  output fps_pkg::q16_t     x
);
  import fps_pkg::*;

  q16_t x_next;

  always_comb begin
    if (angle < -Q_PI) begin
      x_next = angle + Q_TWO_PI;
    end else if (angle > Q_PI) begin
      x_next = angle - Q_TWO_PI;
    end else begin
      x_next = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= x_next;
    end
  end

endmodule : fps_wrap
`default_nettype wire

/* rtl/fps_parab.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fps_parab
// parabola y = k_lin*x -/+ k_quad*x*x, two register stages
// ----------------------------------------------------------------------------
module fps_parab (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire fps_pkg::q16_t x,
  output logic               vld,
  output fps_pkg::q16_t      y
);
  import fps_pkg::*;

  logic vld_a;
  q16_t lin;
  q16_t xx;
  logic neg;
  q16_t quad;
  q16_t y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld   <= 1'b0;
    end else if (en) begin
      vld_a <= in_vld;
      vld   <= vld_a;
    end
  end

  // first stage: linear term and square
  always_ff @(posedge clk) begin
    if (en) begin
      lin <= qmul(K_LIN, x);
      xx  <= qmul(x, x);
      neg <= x[31];
    end
  end

  always_comb begin
    quad = qmul(K_QUAD, xx);
    if (neg) begin
      y_next = lin + quad;
    end else begin
      y_next = lin - quad;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_next;
    end
  end

endmodule : fps_parab
`default_nettype wire

/* rtl/fps_refine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fps_refine
// refinement s = k_refine*(y*|y| - y) + y, two register stages
// ----------------------------------------------------------------------------
module fps_refine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire fps_pkg::q16_t y,
  output logic               vld,
  output fps_pkg::q16_t      sine
);
  import fps_pkg::*;

  logic vld_c;
  q16_t ysq;
  q16_t ysq_s;
  q16_t diff;
  q16_t y_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
      vld   <= 1'b0;
    end else if (en) begin
      vld_c <= in_vld;
      vld   <= vld_c;
    end
  end

  always_comb begin
    ysq   = qmul(y, y);
    ysq_s = y[31] ? -ysq : ysq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= ysq_s - y;
      y_c  <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine <= qmul(K_REFINE, diff) + y_c;
    end
  end

endmodule : fps_refine
`default_nettype wire

/* rtl/fps_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fps_checker
// port-level checks on the sine pipeline, bound to the top level
// ----------------------------------------------------------------------------
module fps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output data changed while stalled");

  a_stall_back: assert property (@(posedge clk)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  a_free_flow: assert property (@(posedge clk) m_tready |-> s_tready)
    else $error("input held off with output free");

endmodule : fps_checker

bind fixed_point_sine_q16 fps_checker u_fps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

/* tb/fixed_point_sine_q16_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_sine_q16_tb
// Streams Q16.16 angles into the sine pipeline and compares every output beat
// against an in-order queue of sines computed here at the same bit widths.
// Directed corner angles come first. Random angles follow: inside +-pi, in
// the band -10..+10, and over the full 32-bit range. Both stream sides
// idle and stall at random, with stretches at full rate.
// ----------------------------------------------------------------------------
module fixed_point_sine_q16_tb;

  typedef fps_pkg::q16_t q16_t;

  typedef struct {
    q16_t angle;
    q16_t sine;
  } sine_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // [31:0] angle
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // [31:0] sine

  sine_entry_t pending_sines[$];
  int          err_cnt  = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  fixed_point_sine_q16 uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // exact product, floor shift, low 32 bits kept
  function automatic q16_t fix_mul(input q16_t a, input q16_t b);
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic signed [63:0] p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> 16;
    return p[31:0];
  endfunction

  function automatic q16_t sine_of(input q16_t angle);
    q16_t x;
    q16_t lin;
    q16_t quad;
    q16_t y;
    q16_t ysq;
    x = angle;
    if (x < -fps_pkg::Q_PI) begin
      x = x + fps_pkg::Q_TWO_PI;
    end else if (x > fps_pkg::Q_PI) begin
      x = x - fps_pkg::Q_TWO_PI;
    end
    lin  = fix_mul(fps_pkg::K_LIN, x);
    quad = fix_mul(fps_pkg::K_QUAD, fix_mul(x, x));
    y    = x[31] ? lin + quad : lin - quad;
    ysq  = fix_mul(y, y);
    if (y[31]) begin
      ysq = -ysq;
    end
    return fix_mul(fps_pkg::K_REFINE, ysq - y) + y;
  endfunction

  task automatic send_angle(input q16_t angle);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= angle;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_sines.push_back('{angle: angle, sine: sine_of(angle)});
  endtask

  // output side stall per beat
  initial begin
    int n;
    forever begin
      n = rx_burst ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sine_entry_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sines.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected beat: expected none actual %h", $time, m_tdata);
      end else begin
        e = pending_sines.pop_front();
        if (m_tdata !== e.sine) begin
          err_cnt++;
          $display("%0t sine mismatch for angle %h: expected %h actual %h",
                   $time, e.angle, e.sine, m_tdata);
        end
      end
    end
  end

  task automatic test_corner_angles();
    q16_t corners[$];
    corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                32'hFFFF_0000, 32'h0000_FFFF, 32'h0001_921F, -32'sh0001_921F,
                fps_pkg::Q_PI, -fps_pkg::Q_PI, fps_pkg::Q_PI + 1,
                -fps_pkg::Q_PI - 1, fps_pkg::Q_PI - 1, fps_pkg::Q_TWO_PI,
                -fps_pkg::Q_TWO_PI, 32'h0009_6CBD, -32'sh0009_6CBD,
                32'h000A_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                32'hAAAA_AAAA};
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    foreach (corners[i]) send_angle(corners[i]);
  endtask

  task automatic test_principal_range();
    q16_t a;
    repeat (300) begin
      if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
      a = $urandom_range(0, 2 * fps_pkg::Q_PI);
      send_angle(a - fps_pkg::Q_PI);
    end
  endtask

  task automatic test_wrap_band();
    q16_t a;
    repeat (250) begin
      if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
      a = $urandom_range(0, 32'h0014_0000);
      send_angle(a - 32'sh000A_0000);
    end
  endtask

  task automatic test_full_range();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    repeat (180) send_angle($urandom());
  endtask

  task automatic test_full_rate();
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (60) send_angle($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0006_0000));
    rx_burst = 1'b0;
    repeat (60) send_angle($urandom());
    tx_burst = 1'b0;
    rx_burst = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_angles();
    test_principal_range();
    test_wrap_band();
    test_full_range();
    test_full_rate();
    s_tvalid <= 1'b0;
    rx_burst = 1'b0;
    while (pending_sines.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
